>>> rtl/dvrt_pkg.sv
// dvrt_pkg: types, codes and constants of the distance-vector route table
// no dependencies
package dvrt_pkg;
	localparam int unsigned NODES = 8;
	localparam int unsigned IW = $clog2(NODES);
	localparam int unsigned CW = 12;
	localparam int unsigned MW = 4;
	localparam logic [CW-1:0] COST_INF = {CW{1'b1}};
	localparam logic [MW-1:0] CNT_MAX = {MW{1'b1}};

	typedef enum logic [2:0] {
		REQ_VECTOR = 3'd0,
		REQ_LINK = 3'd1,
		REQ_TICK = 3'd2,
		REQ_READ = 3'd3,
		REQ_DISABLE = 3'd4,
		REQ_RESTART = 3'd5
	} req_code_t;

	typedef enum logic [1:0] {
		ST_DONE_CODE = 2'd0,
		ST_IGNORED = 2'd1,
		ST_BUFFERED = 2'd2
	} status_code_t;

	localparam logic [1:0] CFG_SELF = 2'd0;
	localparam logic [1:0] CFG_MASK = 2'd1;
	localparam logic [1:0] CFG_TIMEOUT = 2'd2;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_WALK,
		S_DONE
	} state_t;

	typedef struct packed {
		logic capture;
		logic exec;
		logic walk;
		logic finish;
		logic [IW-1:0] idx;
	} cmd_t;

	typedef struct packed {
		logic need_walk;
	} sts_t;

	typedef struct packed {
		logic [2:0] req_type;
		logic [IW-1:0] node_id;
		logic [IW-1:0] dest_id;
		logic [CW-1:0] entry_cost;
		logic last_entry;
		logic periodic;
		logic [CW-1:0] link_cost;
	} req_t;
endpackage

>>> rtl/distance_vector_route_table.sv
// channel   | handshake            | payload
// request   | in_valid / in_ready  | req_type node_id dest_id entry_cost last_entry periodic link_cost
// result    | out_valid / out_ready| status next_hop route_cost reachable live_mask timed_out_mask
// config    | cfg_we               | cfg_idx cfg_wdata
// one request at a time; the 8-entry table walk runs in addition on these requests
// (last vector entry, dropped neighbour, tick)
// a new request is taken while the previous result still waits in the output register
// a stalled result holds the sequencer in its final state
// arst_n clears all tables to their startup values at once
module distance_vector_route_table (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [1:0] cfg_idx,
	input  logic [7:0] cfg_wdata,
	input  logic in_valid,
	output logic in_ready,
	input  logic [2:0] req_type,
	input  logic [dvrt_pkg::IW-1:0] node_id,
	input  logic [dvrt_pkg::IW-1:0] dest_id,
	input  logic [dvrt_pkg::CW-1:0] entry_cost,
	input  logic last_entry,
	input  logic periodic,
	input  logic [dvrt_pkg::CW-1:0] link_cost,
	output logic out_valid,
	input  logic out_ready,
	output logic [1:0] status,
	output logic [dvrt_pkg::IW-1:0] next_hop,
	output logic [dvrt_pkg::CW-1:0] route_cost,
	output logic reachable,
	output logic [dvrt_pkg::NODES-1:0] live_mask,
	output logic [dvrt_pkg::NODES-1:0] timed_out_mask
);
	import dvrt_pkg::*;

	cmd_t cmd;
	sts_t sts;
	req_t req_in;

	always_comb begin
		req_in.req_type = req_type;
		req_in.node_id = node_id;
		req_in.dest_id = dest_id;
		req_in.entry_cost = entry_cost;
		req_in.last_entry = last_entry;
		req_in.periodic = periodic;
		req_in.link_cost = link_cost;
	end

	dvrt_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.sts(sts),
		.cmd(cmd)
	);

	dvrt_dp u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_wdata(cfg_wdata),
		.req_in(req_in),
		.cmd(cmd),
		.sts(sts),
		.status(status),
		.next_hop(next_hop),
		.route_cost(route_cost),
		.reachable(reachable),
		.live_mask(live_mask),
		.timed_out_mask(timed_out_mask)
	);
endmodule

>>> rtl/dvrt_ctrl.sv
// dvrt_ctrl: sequencer of accept, execute, table walk and result load
// depends on dvrt_pkg
module dvrt_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input  logic out_ready,
	input  dvrt_pkg::sts_t sts,
	output dvrt_pkg::cmd_t cmd
);
	import dvrt_pkg::*;

	state_t state_q, state_d;
	logic [IW-1:0] idx_q;
	logic out_valid_q;
	logic slot_free;

	assign slot_free = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: if (in_valid) state_d = S_EXEC;
			S_EXEC: state_d = sts.need_walk ? S_WALK : S_DONE;
			S_WALK: if (idx_q == IW'(NODES - 1)) state_d = S_DONE;
			S_DONE: if (slot_free) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		in_ready = (state_q == S_IDLE);
		cmd.capture = (state_q == S_IDLE) && in_valid;
		cmd.exec = (state_q == S_EXEC);
		cmd.walk = (state_q == S_WALK);
		cmd.finish = (state_q == S_DONE) && slot_free;
		cmd.idx = idx_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_WALK) idx_q <= idx_q + 1'b1;
			else idx_q <= '0;
			if (cmd.finish) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end
endmodule

>>> rtl/dvrt_dp.sv
// dvrt_dp: route tables, neighbour state, vector buffer and result register
// depends on dvrt_pkg; driven by dvrt_ctrl commands
module dvrt_dp (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [1:0] cfg_idx,
	input  logic [7:0] cfg_wdata,
	input  dvrt_pkg::req_t req_in,
	input  dvrt_pkg::cmd_t cmd,
	output dvrt_pkg::sts_t sts,
	output logic [1:0] status,
	output logic [dvrt_pkg::IW-1:0] next_hop,
	output logic [dvrt_pkg::CW-1:0] route_cost,
	output logic reachable,
	output logic [dvrt_pkg::NODES-1:0] live_mask,
	output logic [dvrt_pkg::NODES-1:0] timed_out_mask
);
	import dvrt_pkg::*;

	logic [IW-1:0] self_q;
	logic [NODES-1:0] nmask_q;
	logic [MW-1:0] timeout_q;
	req_t req_q;

	logic [CW-1:0] cost_q [NODES], cost_d [NODES];
	logic [IW-1:0] hop_q [NODES], hop_d [NODES];
	logic [NODES-1:0] hh_q, hh_d;
	logic [MW-1:0] cnt_q [NODES], cnt_d [NODES];
	logic [CW-1:0] buf_q [NODES], buf_d [NODES];
	logic [NODES-1:0] live_q, live_d;
	logic [NODES-1:0] kill_q, kill_d;
	logic relax_q, relax_d;
	logic [CW-1:0] link_q, link_d;

	logic [1:0] rstat_q, rstat_d;
	logic [IW-1:0] rhop_q, rhop_d;
	logic [CW-1:0] rcost_q, rcost_d;
	logic [NODES-1:0] dead_q, dead_d;

	logic [1:0] ostat_q;
	logic [IW-1:0] ohop_q;
	logic [CW-1:0] ocost_q;
	logic oreach_q;
	logic [NODES-1:0] olive_q, odead_q;

	logic nlive;
	logic [CW-1:0] vlink;
	logic [MW-1:0] inc;
	logic [IW-1:0] c;
	logic [CW:0] sum;
	logic [CW-1:0] s, r;
	logic h;

	assign nlive = live_q[req_q.node_id];

	always_comb begin
		cost_d = cost_q;
		hop_d = hop_q;
		hh_d = hh_q;
		cnt_d = cnt_q;
		buf_d = buf_q;
		live_d = live_q;
		kill_d = kill_q;
		relax_d = relax_q;
		link_d = link_q;
		rstat_d = rstat_q;
		rhop_d = rhop_q;
		rcost_d = rcost_q;
		dead_d = dead_q;
		sts.need_walk = 1'b0;
		vlink = (req_q.dest_id == self_q) ? req_q.entry_cost : buf_q[self_q];
		inc = '0;
		c = cmd.idx;
		sum = {1'b0, link_q} + {1'b0, buf_q[c]};
		s = (sum >= {1'b0, COST_INF}) ? COST_INF : sum[CW-1:0];
		r = cost_q[c];
		h = hh_q[c];

		if (cmd.exec) begin
			rstat_d = ST_DONE_CODE;
			rhop_d = '0;
			rcost_d = '0;
			dead_d = '0;
			kill_d = '0;
			relax_d = 1'b0;
			unique case (req_q.req_type)
				REQ_VECTOR: begin
					if (!nlive) begin
						rstat_d = ST_IGNORED;
					end else begin
						buf_d[req_q.dest_id] = req_q.entry_cost;
						if (!req_q.last_entry) begin
							rstat_d = ST_BUFFERED;
						end else begin
							if (req_q.periodic) cnt_d[req_q.node_id] = '0;
							sts.need_walk = 1'b1;
							if (vlink == COST_INF) begin
								kill_d[req_q.node_id] = 1'b1;
								live_d[req_q.node_id] = 1'b0;
								cnt_d[req_q.node_id] = '0;
								for (int i = 0; i < NODES; i++) buf_d[i] = COST_INF;
							end else begin
								relax_d = 1'b1;
								link_d = vlink;
								cost_d[req_q.node_id] = vlink;
								hop_d[req_q.node_id] = req_q.node_id;
								hh_d[req_q.node_id] = 1'b1;
							end
						end
					end
				end
				REQ_LINK: begin
					if (!nlive) begin
						rstat_d = ST_IGNORED;
					end else if (req_q.link_cost == COST_INF) begin
						sts.need_walk = 1'b1;
						kill_d[req_q.node_id] = 1'b1;
						live_d[req_q.node_id] = 1'b0;
						cnt_d[req_q.node_id] = '0;
					end else begin
						cost_d[req_q.node_id] = req_q.link_cost;
						hop_d[req_q.node_id] = req_q.node_id;
						hh_d[req_q.node_id] = 1'b1;
					end
				end
				REQ_TICK: begin
					sts.need_walk = 1'b1;
					for (int i = 0; i < NODES; i++) begin
						if (live_q[i]) begin
							inc = (cnt_q[i] == CNT_MAX) ? CNT_MAX : cnt_q[i] + 1'b1;
							if (inc >= timeout_q) begin
								kill_d[i] = 1'b1;
								dead_d[i] = 1'b1;
								live_d[i] = 1'b0;
								cnt_d[i] = '0;
							end else begin
								cnt_d[i] = inc;
							end
						end
					end
				end
				REQ_READ: begin
					rcost_d = cost_q[req_q.dest_id];
					if (hh_q[req_q.dest_id]) rhop_d = hop_q[req_q.dest_id];
					else if (req_q.dest_id == self_q) rhop_d = self_q;
				end
				REQ_DISABLE: begin
					if (!nlive) begin
						rstat_d = ST_IGNORED;
					end else begin
						sts.need_walk = 1'b1;
						kill_d[req_q.node_id] = 1'b1;
						live_d[req_q.node_id] = 1'b0;
						cnt_d[req_q.node_id] = '0;
					end
				end
				REQ_RESTART: begin
					for (int i = 0; i < NODES; i++) begin
						cost_d[i] = COST_INF;
						hop_d[i] = '0;
						cnt_d[i] = '0;
						buf_d[i] = COST_INF;
					end
					hh_d = '0;
					live_d = nmask_q;
					live_d[self_q] = 1'b0;
					cost_d[self_q] = '0;
					hop_d[self_q] = self_q;
				end
				default: rstat_d = ST_IGNORED;
			endcase
		end

		if (cmd.walk) begin
			if (relax_q) begin
				if (c != self_q && c != req_q.node_id) begin
					if (h && hop_q[c] == req_q.node_id) begin
						if (buf_q[c] == COST_INF) begin
							r = COST_INF;
							h = 1'b0;
						end else begin
							r = s;
							h = (s != COST_INF);
						end
					end
					if (buf_q[c] != COST_INF && s < r) begin
						r = s;
						h = 1'b1;
						hop_d[c] = req_q.node_id;
					end
					cost_d[c] = r;
					hh_d[c] = h;
				end
			end else if (kill_q[c] || (h && kill_q[hop_q[c]])) begin
				cost_d[c] = COST_INF;
				hh_d[c] = 1'b0;
			end
		end

		if (cmd.finish && relax_q) begin
			for (int i = 0; i < NODES; i++) buf_d[i] = COST_INF;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			self_q <= '0;
			nmask_q <= '0;
			timeout_q <= MW'(4);
			hh_q <= '0;
			live_q <= '0;
			kill_q <= '0;
			relax_q <= 1'b0;
			for (int i = 0; i < NODES; i++) begin
				cost_q[i] <= COST_INF;
				hop_q[i] <= '0;
				cnt_q[i] <= '0;
				buf_q[i] <= COST_INF;
			end
		end else begin
			if (cfg_we) begin
				unique case (cfg_idx)
					CFG_SELF: self_q <= cfg_wdata[IW-1:0];
					CFG_MASK: nmask_q <= cfg_wdata[NODES-1:0];
					CFG_TIMEOUT: timeout_q <= cfg_wdata[MW-1:0];
					default: ;
				endcase
			end
			cost_q <= cost_d;
			hop_q <= hop_d;
			hh_q <= hh_d;
			cnt_q <= cnt_d;
			buf_q <= buf_d;
			live_q <= live_d;
			kill_q <= kill_d;
			relax_q <= relax_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) req_q <= req_in;
		link_q <= link_d;
		rstat_q <= rstat_d;
		rhop_q <= rhop_d;
		rcost_q <= rcost_d;
		dead_q <= dead_d;
		if (cmd.finish) begin
			ostat_q <= rstat_q;
			ohop_q <= rhop_q;
			ocost_q <= rcost_q;
			oreach_q <= (req_q.req_type == REQ_READ) && (rcost_q != COST_INF);
			olive_q <= live_q;
			odead_q <= dead_q;
		end
	end

	assign status = ostat_q;
	assign next_hop = ohop_q;
	assign route_cost = ocost_q;
	assign reachable = oreach_q;
	assign live_mask = olive_q;
	assign timed_out_mask = odead_q;
endmodule

>>> rtl/dvrt_chk.sv
// dvrt_chk: port-level checks of the route table, bound to the top level
// depends on dvrt_pkg
module dvrt_chk (
	input logic clk,
	input logic arst_n,
	input logic out_valid,
	input logic out_ready,
	input logic [1:0] status,
	input logic [dvrt_pkg::IW-1:0] next_hop,
	input logic [dvrt_pkg::CW-1:0] route_cost,
	input logic reachable,
	input logic [dvrt_pkg::NODES-1:0] timed_out_mask
);
	import dvrt_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(route_cost))
		else $error("result changed while stalled");

	a_reach: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && reachable |-> route_cost != COST_INF)
		else $error("reachable set on an infinite route cost");

	a_dead: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && timed_out_mask != '0 |-> status == ST_DONE_CODE && route_cost == '0)
		else $error("timeout reported on a non-tick result");

	a_buf: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_BUFFERED |-> next_hop == '0 && timed_out_mask == '0)
		else $error("buffered entry carries route data");
endmodule

bind distance_vector_route_table dvrt_chk u_chk (
	.clk(clk),
	.arst_n(arst_n),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.status(status),
	.next_hop(next_hop),
	.route_cost(route_cost),
	.reachable(reachable),
	.timed_out_mask(timed_out_mask)
);

>>> sim/dvrt_checker.sv
// dvrt_checker: watches the config port and both channels of the route table,
// keeps its own copy of the routing state, predicts each result and compares
// depends on dvrt_pkg
module dvrt_checker
	import dvrt_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [1:0] cfg_idx,
	input  logic [7:0] cfg_wdata,
	input  logic in_valid,
	input  logic in_ready,
	input  logic [2:0] req_type,
	input  logic [IW-1:0] node_id,
	input  logic [IW-1:0] dest_id,
	input  logic [CW-1:0] entry_cost,
	input  logic last_entry,
	input  logic periodic,
	input  logic [CW-1:0] link_cost,
	input  logic out_valid,
	input  logic out_ready,
	input  logic [1:0] status,
	input  logic [IW-1:0] next_hop,
	input  logic [CW-1:0] route_cost,
	input  logic reachable,
	input  logic [NODES-1:0] live_mask,
	input  logic [NODES-1:0] timed_out_mask,
	output int fail_count,
	output int pending
);
	typedef struct packed {
		logic [1:0] st;
		logic [IW-1:0] hop;
		logic [CW-1:0] cost;
		logic reach;
		logic [NODES-1:0] live;
		logic [NODES-1:0] dead;
	} answer_t;

	logic [IW-1:0] my_id;
	logic [NODES-1:0] nbr_cfg;
	logic [MW-1:0] max_misses;
	logic [CW-1:0] cost_tbl [NODES];
	logic [IW-1:0] hop_tbl [NODES];
	logic has_hop [NODES];
	logic [CW-1:0] link_tbl [NODES];
	logic [NODES-1:0] live_nbrs;
	logic [MW-1:0] misses [NODES];
	logic [CW-1:0] vec_buf [NODES];
	answer_t awaited [$];

	function automatic logic [CW-1:0] cost_sum(logic [CW-1:0] a, logic [CW-1:0] b);
		logic [CW:0] s;
		s = a + b;
		return (s >= COST_INF) ? COST_INF : s[CW-1:0];
	endfunction

	task automatic wipe_tables();
		for (int i = 0; i < NODES; i++) begin
			cost_tbl[i] = COST_INF;
			hop_tbl[i] = '0;
			has_hop[i] = 1'b0;
			link_tbl[i] = COST_INF;
			misses[i] = '0;
			vec_buf[i] = COST_INF;
		end
		live_nbrs = '0;
	endtask

	task automatic drop_nbr(int n);
		live_nbrs[n] = 1'b0;
		link_tbl[n] = COST_INF;
		cost_tbl[n] = COST_INF;
		has_hop[n] = 1'b0;
		misses[n] = '0;
		for (int c = 0; c < NODES; c++)
			if (has_hop[c] && hop_tbl[c] == n) begin
				cost_tbl[c] = COST_INF;
				has_hop[c] = 1'b0;
			end
	endtask

	task automatic merge_vector(int n, logic per);
		logic [CW-1:0] lk;
		logic [CW-1:0] s;
		if (per)
			misses[n] = '0;
		lk = vec_buf[my_id];
		if (lk == COST_INF) begin
			drop_nbr(n);
		end else begin
			link_tbl[n] = lk;
			cost_tbl[n] = lk;
			hop_tbl[n] = IW'(n);
			has_hop[n] = 1'b1;
			for (int c = 0; c < NODES; c++) begin
				if (c == my_id || c == n)
					continue;
				if (has_hop[c] && hop_tbl[c] == n) begin
					if (vec_buf[c] == COST_INF) begin
						cost_tbl[c] = COST_INF;
						has_hop[c] = 1'b0;
					end else begin
						cost_tbl[c] = cost_sum(lk, vec_buf[c]);
						if (cost_tbl[c] == COST_INF)
							has_hop[c] = 1'b0;
					end
				end
			end
			for (int c = 0; c < NODES; c++) begin
				if (c == my_id || c == n || vec_buf[c] == COST_INF)
					continue;
				s = cost_sum(lk, vec_buf[c]);
				if (s < cost_tbl[c]) begin
					cost_tbl[c] = s;
					hop_tbl[c] = IW'(n);
					has_hop[c] = 1'b1;
				end
			end
		end
		for (int c = 0; c < NODES; c++)
			vec_buf[c] = COST_INF;
	endtask

	task automatic apply_request(output answer_t a);
		a = '0;
		case (req_type)
			REQ_VECTOR: begin
				if (!live_nbrs[node_id]) begin
					a.st = ST_IGNORED;
				end else begin
					vec_buf[dest_id] = entry_cost;
					if (last_entry)
						merge_vector(node_id, periodic);
					else
						a.st = ST_BUFFERED;
				end
			end
			REQ_LINK: begin
				if (!live_nbrs[node_id]) begin
					a.st = ST_IGNORED;
				end else if (link_cost == COST_INF) begin
					drop_nbr(node_id);
				end else begin
					link_tbl[node_id] = link_cost;
					cost_tbl[node_id] = link_cost;
					hop_tbl[node_id] = node_id;
					has_hop[node_id] = 1'b1;
				end
			end
			REQ_TICK: begin
				for (int i = 0; i < NODES; i++) begin
					if (!live_nbrs[i])
						continue;
					if (misses[i] != CNT_MAX)
						misses[i]++;
					if (misses[i] >= max_misses) begin
						drop_nbr(i);
						a.dead[i] = 1'b1;
					end
				end
			end
			REQ_READ: begin
				a.cost = cost_tbl[dest_id];
				if (has_hop[dest_id])
					a.hop = hop_tbl[dest_id];
				else if (dest_id == my_id)
					a.hop = my_id;
				a.reach = (a.cost != COST_INF);
			end
			REQ_DISABLE: begin
				if (!live_nbrs[node_id])
					a.st = ST_IGNORED;
				else
					drop_nbr(node_id);
			end
			REQ_RESTART: begin
				wipe_tables();
				live_nbrs = nbr_cfg;
				live_nbrs[my_id] = 1'b0;
				cost_tbl[my_id] = '0;
				hop_tbl[my_id] = my_id;
				link_tbl[my_id] = '0;
			end
			default: a.st = ST_IGNORED;
		endcase
		a.live = live_nbrs;
	endtask

	always @(posedge clk or negedge arst_n) begin
		answer_t a, got;
		if (!arst_n) begin
			my_id = '0;
			nbr_cfg = '0;
			max_misses = 4'd4;
			wipe_tables();
			awaited.delete();
			fail_count = 0;
			pending = 0;
		end else begin
			if (cfg_we)
				case (cfg_idx)
					CFG_SELF: my_id = cfg_wdata[IW-1:0];
					CFG_MASK: nbr_cfg = cfg_wdata;
					CFG_TIMEOUT: max_misses = cfg_wdata[MW-1:0];
					default: ;
				endcase
			if (out_valid && out_ready) begin
				got = '{status, next_hop, route_cost, reachable, live_mask, timed_out_mask};
				if (awaited.size() == 0) begin
					if (fail_count < 10)
						$display("unexpected result transfer: %p", got);
					fail_count++;
				end else begin
					a = awaited.pop_front();
					if (got !== a) begin
						if (fail_count < 10)
							$display("result mismatch: expected %p actual %p", a, got);
						fail_count++;
					end
				end
			end
			if (in_valid && in_ready) begin
				apply_request(a);
				awaited.push_back(a);
			end
			pending = awaited.size();
		end
	end
endmodule

>>> sim/distance_vector_route_table_test.sv
// distance_vector_route_table_test: drives config writes and request transfers
// with random gaps and stalls; the checker predicts and compares results
// depends on dvrt_pkg, distance_vector_route_table and dvrt_checker
module distance_vector_route_table_test;
	import dvrt_pkg::*;

	localparam logic [2:0] REQ_SPARE_A = 3'd6;
	localparam logic [2:0] REQ_SPARE_B = 3'd7;
	localparam int CYCLE_LIMIT = 600000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_idx = '0;
	logic [7:0] cfg_wdata = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [2:0] req_type = '0;
	logic [IW-1:0] node_id = '0;
	logic [IW-1:0] dest_id = '0;
	logic [CW-1:0] entry_cost = '0;
	logic last_entry = 1'b0;
	logic periodic = 1'b0;
	logic [CW-1:0] link_cost = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [1:0] status;
	logic [IW-1:0] next_hop;
	logic [CW-1:0] route_cost;
	logic reachable;
	logic [NODES-1:0] live_mask;
	logic [NODES-1:0] timed_out_mask;
	int fail_count;
	int pending;
	int send_idle = 0;
	int recv_idle = 0;
	logic hold_go = 1'b0;
	int stall_left = 0;
	int cycles = 0;
	int sent = 0;
	logic [IW-1:0] cur_self = '0;
	logic [NODES-1:0] cur_mask = '0;

	distance_vector_route_table dut (.*);
	dvrt_checker checker_i (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("distance_vector_route_table_test failed");
			$finish;
		end
	end

	// long receiver hold-off so the block backs up
	always @(posedge clk) begin
		if (hold_go && stall_left == 0)
			stall_left <= 300;
		else if (stall_left != 0)
			stall_left <= stall_left - 1;
		out_ready <= (stall_left == 0) && ($urandom_range(99) >= recv_idle);
	end

	function automatic logic [IW-1:0] rand_id();
		return IW'($urandom);
	endfunction

	function automatic logic [CW-1:0] rand_cost();
		return CW'($urandom);
	endfunction

	function automatic logic rand_bit();
		return 1'($urandom);
	endfunction

	task automatic send(logic [2:0] rt, logic [IW-1:0] nd, logic [IW-1:0] ds,
			logic [CW-1:0] ec, logic le, logic pe, logic [CW-1:0] lc);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		req_type <= rt;
		node_id <= nd;
		dest_id <= ds;
		entry_cost <= ec;
		last_entry <= le;
		periodic <= pe;
		link_cost <= lc;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		sent++;
	endtask

	task automatic configure(logic [IW-1:0] s, logic [7:0] m, logic [MW-1:0] t);
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= CFG_SELF;
		cfg_wdata <= 8'(s);
		@(posedge clk);
		cfg_idx <= CFG_MASK;
		cfg_wdata <= m;
		@(posedge clk);
		cfg_idx <= CFG_TIMEOUT;
		cfg_wdata <= 8'(t);
		@(posedge clk);
		cfg_we <= 1'b0;
		cur_self = s;
		cur_mask = m;
	endtask

	function automatic logic [CW-1:0] pick_cost();
		case ($urandom_range(5))
			0: return COST_INF;
			1: return CW'($urandom_range(COST_INF));
			2: return COST_INF - 1'b1;
			default: return CW'($urandom_range(20));
		endcase
	endfunction

	function automatic logic [IW-1:0] pick_nbr();
		logic [IW-1:0] n;
		for (int k = 0; k < 16; k++) begin
			n = rand_id();
			if (cur_mask[n] && n != cur_self)
				return n;
		end
		return rand_id();
	endfunction

	task automatic send_vector(logic [IW-1:0] n);
		int cnt;
		cnt = $urandom_range(6);
		for (int k = 0; k < cnt; k++)
			send(REQ_VECTOR, n, rand_id(), pick_cost(), 1'b0, rand_bit(), rand_cost());
		if ($urandom_range(7) == 0)
			send(REQ_VECTOR, n, rand_id(), pick_cost(), 1'b1, rand_bit(), rand_cost());
		else
			send(REQ_VECTOR, n, cur_self, CW'($urandom_range(1, 30)), 1'b1,
				$urandom_range(3) != 0, rand_cost());
	endtask

	task automatic random_phase(int items);
		int first;
		logic [IW-1:0] n;
		first = sent;
		while (sent - first < items) begin
			n = pick_nbr();
			case ($urandom_range(19))
				0, 1, 2, 3, 4, 5, 6, 7: send_vector(n);
				8: send(REQ_LINK, n, rand_id(), rand_cost(), rand_bit(), rand_bit(),
					pick_cost());
				9: send(REQ_LINK, rand_id(), rand_id(), rand_cost(), rand_bit(), rand_bit(),
					CW'($urandom_range(COST_INF)));
				10, 11: send(REQ_TICK, rand_id(), rand_id(), rand_cost(), rand_bit(),
					rand_bit(), rand_cost());
				12, 13, 14: send(REQ_READ, rand_id(), rand_id(), rand_cost(), rand_bit(),
					rand_bit(), rand_cost());
				15: send($urandom_range(1) ? REQ_DISABLE : REQ_RESTART, n, rand_id(),
					rand_cost(), rand_bit(), rand_bit(), rand_cost());
				16: send(REQ_RESTART, rand_id(), rand_id(), rand_cost(), rand_bit(),
					rand_bit(), rand_cost());
				17: send(3'($urandom_range(REQ_SPARE_A, REQ_SPARE_B)), rand_id(), rand_id(),
					rand_cost(), rand_bit(), rand_bit(), rand_cost());
				default: send(3'($urandom), rand_id(), rand_id(), rand_cost(), rand_bit(),
					rand_bit(), rand_cost());
			endcase
		end
	endtask

	initial begin
		logic [IW-1:0] sid [6] = '{3'd0, 3'd7, 3'd3, 3'd5, 3'd1, 3'd6};
		logic [7:0] msk [6] = '{8'hFF, 8'hFF, 8'h5A, 8'hA5, 8'h00, 8'hFE};
		logic [MW-1:0] tmo [6] = '{4'd2, 4'd15, 4'd1, 4'd4, 4'd0, 4'd7};
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reads and requests straight out of reset
		send(REQ_READ, 0, 0, 0, 0, 0, 0);
		send(REQ_VECTOR, 1, 2, 5, 1, 1, 0);
		send(REQ_TICK, 0, 0, 0, 0, 0, 0);
		configure(3'd0, 8'hFF, 4'd2);
		send(REQ_RESTART, 0, 0, 0, 0, 0, 0);
		send(REQ_READ, 0, 0, 0, 0, 0, 0);
		send(REQ_VECTOR, 1, 3, 12'd0, 0, 1, 0);
		send(REQ_VECTOR, 1, 7, COST_INF - 1'b1, 0, 1, 0);
		send(REQ_VECTOR, 1, 0, 12'd5, 1, 1, 0);
		send(REQ_READ, 0, 3, 0, 0, 0, 0);
		send(REQ_READ, 0, 7, 0, 0, 0, 0);
		send(REQ_VECTOR, 2, 3, 12'd1, 0, 0, 0);
		send(REQ_VECTOR, 2, 0, 12'd1, 1, 0, 0);
		send(REQ_READ, 0, 3, 0, 0, 0, 0);
		send(REQ_VECTOR, 1, 0, COST_INF, 1, 1, 0);
		send(REQ_LINK, 2, 0, 0, 0, 0, 12'hFFF);
		send(REQ_LINK, 3, 7, 12'hFFF, 1, 1, 12'd0);
		send(REQ_LINK, 0, 0, 0, 0, 0, 12'd9);
		send(REQ_DISABLE, 3, 0, 0, 0, 0, 0);
		send(REQ_DISABLE, 3, 0, 0, 0, 0, 0);
		send(REQ_TICK, 0, 0, 0, 0, 0, 0);
		send(REQ_TICK, 0, 0, 0, 0, 0, 0);
		send(REQ_SPARE_A, 7, 7, 12'hFFF, 1, 1, 12'hFFF);
		send(REQ_SPARE_B, 0, 0, 0, 0, 0, 0);
		send(REQ_READ, 0, 3, 0, 0, 0, 0);

		for (int p = 0; p < 6; p++) begin
			send_idle = (p < 2) ? 12 : (p < 4) ? 59 : 0;
			recv_idle = (p < 2) ? 59 : (p < 4) ? 12 : 0;
			configure(sid[p], msk[p], tmo[p]);
			send(REQ_RESTART, 0, 0, 0, 0, 0, 0);
			if (p == 4)
				hold_go <= 1'b1;
			random_phase(180);
			hold_go <= 1'b0;
		end
		in_valid <= 1'b0;

		while (pending != 0)
			@(posedge clk);
		repeat (30) @(posedge clk);
		if (fail_count == 0)
			$display("distance_vector_route_table_test passed");
		else
			$display("distance_vector_route_table_test failed");
		$finish;
	end
endmodule
